@@ rtl/assert_macros.svh @@
// Assertion macros shared by the reorder buffer RTL.
// Depends on nothing; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TRB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TRB_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define TRB_ASSERT(label, clk, rst_n, prop)
`define TRB_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ rtl/trb_pkg.sv @@
// Shared constants, codes and types of the transport reorder buffer.
// Depends on nothing.
package trb_pkg;
    localparam int TABLE_ENTRIES = 16;
    localparam int ACK_ENTRIES   = 16;
    localparam int RESULT_CAP    = 16;
    localparam int TIDX_W        = $clog2(TABLE_ENTRIES);
    localparam int AIDX_W        = $clog2(ACK_ENTRIES);
    localparam int ACNT_W        = $clog2(ACK_ENTRIES + 1);
    localparam logic [31:0] MAX_BYTES_RST = 32'd32768;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_NEXT = 2'd1,
        CMD_ACKS = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_STORED = 4'd0,
        ST_OVER   = 4'd1,
        ST_DUP    = 4'd2,
        ST_POPPED = 4'd3,
        ST_PEEKED = 4'd4,
        ST_EMPTY  = 4'd5,
        ST_ACK    = 4'd6,
        ST_NOACK  = 4'd7,
        ST_FULL   = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PEEK,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic write;
        logic drop;
    } cell_ctl_t;
endpackage

@@ rtl/trb_entry_cell.sv @@
// One segment table entry: valid bit, sequence, length and handle.
// Depends on trb_pkg; chained to its neighbours through the free-slot chain.
module trb_entry_cell
    import trb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctl_t   ctl,
    input  logic [31:0] seq_in,
    input  logic [15:0] len_in,
    input  logic [15:0] handle_in,
    input  logic [31:0] key,
    input  logic        free_in,
    output logic        free_out,
    output logic        first_free,
    output logic        valid,
    output logic        match,
    output logic [31:0] seq,
    output logic [15:0] len,
    output logic [15:0] handle
);
    logic        valid_reg;
    logic [31:0] seq_reg;
    logic [15:0] len_reg;
    logic [15:0] handle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.write)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.drop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            seq_reg    <= seq_in;
            len_reg    <= len_in;
            handle_reg <= handle_in;
        end
    end

    assign free_out   = free_in & valid_reg;
    assign first_free = free_in & ~valid_reg;
    assign valid      = valid_reg;
    assign match      = valid_reg && (seq_reg == key);
    assign seq        = seq_reg;
    assign len        = len_reg;
    assign handle     = handle_reg;
endmodule

@@ rtl/trb_ack_cell.sv @@
// One pending acknowledgement slot: valid bit and sequence.
// Depends on trb_pkg; chained to its neighbours through the free-slot chain.
module trb_ack_cell
    import trb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctl_t   ctl,
    input  logic [31:0] seq_in,
    input  logic        free_in,
    output logic        free_out,
    output logic        first_free,
    output logic        valid,
    output logic        match,
    output logic [31:0] seq
);
    logic        valid_reg;
    logic [31:0] seq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.write)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.drop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            seq_reg <= seq_in;
        end
    end

    assign free_out   = free_in & valid_reg;
    assign first_free = free_in & ~valid_reg;
    assign valid      = valid_reg;
    assign match      = valid_reg && (seq_reg == seq_in);
    assign seq        = seq_reg;
endmodule

@@ rtl/transport_reorder_buffer.sv @@
// Top level of the receive reorder buffer: command sequencer, counters, cell rows.
// Depends on trb_pkg, trb_entry_cell, trb_ack_cell and assert_macros.svh.
//
// channel   | handshake                 | payload
// command   | start / busy              | command, segment_seq, segment_length, packet_handle
// result    | result_valid (one cycle)  | status, handle_out, seq_out, last_result,
//           |                           | bytes_in_buffer, next_expected_seq, ack_overflow
// config    | max_buffer_bytes_we       | max_buffer_bytes
//
// Add, in-order next, empty and no-ack: matched in S_EXEC, result shown in the next cycle.
// Peek: S_PEEK examines one table cell per cycle and shows the result after the last cell.
// Acks: for each ack, S_DRAIN scans all ack slots and shows the smallest pending sequence.
// Reset clears all valid bits, counters and the sequencer; no clearing pass.
// Results cannot be stalled; busy falls as the last result is registered, so a new
// transfer may be taken in the cycle that shows it.
`include "assert_macros.svh"
module transport_reorder_buffer
    import trb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] segment_seq,
    input  logic [15:0] segment_length,
    input  logic [15:0] packet_handle,
    input  logic        max_buffer_bytes_we,
    input  logic [31:0] max_buffer_bytes,
    output logic        result_valid,
    output logic [3:0]  status,
    output logic [15:0] handle_out,
    output logic [31:0] seq_out,
    output logic        last_result,
    output logic [31:0] bytes_in_buffer,
    output logic [31:0] next_expected_seq,
    output logic        ack_overflow
);
    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    logic [31:0] seq_reg;
    logic [15:0] len_reg;
    logic [15:0] hd_reg;
    logic [31:0] max_reg;
    logic [31:0] held_reg, held_next;
    logic [31:0] exp_reg, exp_next;
    logic [TIDX_W-1:0] t_idx_reg, t_idx_next;
    logic [AIDX_W-1:0] a_idx_reg, a_idx_next;
    logic        best_vld_reg, best_vld_next;
    logic [31:0] best_key_reg, best_key_next;
    logic [TIDX_W-1:0] best_t_reg, best_t_next;
    logic [AIDX_W-1:0] best_a_reg, best_a_next;
    logic [ACNT_W-1:0] remain_reg, remain_next;

    logic        strobe_reg, strobe_next;
    logic [3:0]  status_reg, status_next;
    logic [15:0] hout_reg, hout_next;
    logic [31:0] sout_reg, sout_next;
    logic        last_reg, last_next;
    logic        ovf_reg, ovf_next;

    cell_ctl_t   e_ctl [TABLE_ENTRIES];
    logic [TABLE_ENTRIES:0] e_chain;
    logic [TABLE_ENTRIES-1:0] e_first, e_valid, e_match;
    logic [31:0] e_seq [TABLE_ENTRIES];
    logic [15:0] e_len [TABLE_ENTRIES];
    logic [15:0] e_hd  [TABLE_ENTRIES];
    logic [31:0] e_key;

    cell_ctl_t   a_ctl [ACK_ENTRIES];
    logic [ACK_ENTRIES:0] a_chain;
    logic [ACK_ENTRIES-1:0] a_first, a_valid, a_match;
    logic [31:0] a_seq [ACK_ENTRIES];

    logic [15:0] hit_len, hit_hd;
    logic [ACNT_W-1:0] a_count;
    logic [32:0] sum_bytes;
    logic        cur_take;
    logic [31:0] cur_key;
    logic [31:0] f_key;
    logic [TIDX_W-1:0] f_t;
    logic [AIDX_W-1:0] f_a;

    assign e_key      = (cmd_reg == CMD_ADD) ? seq_reg : exp_reg;
    assign e_chain[0] = 1'b1;
    assign a_chain[0] = 1'b1;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_entry
        trb_entry_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (e_ctl[i]),
            .seq_in     (seq_reg),
            .len_in     (len_reg),
            .handle_in  (hd_reg),
            .key        (e_key),
            .free_in    (e_chain[i]),
            .free_out   (e_chain[i+1]),
            .first_free (e_first[i]),
            .valid      (e_valid[i]),
            .match      (e_match[i]),
            .seq        (e_seq[i]),
            .len        (e_len[i]),
            .handle     (e_hd[i])
        );
    end

    for (genvar j = 0; j < ACK_ENTRIES; j++)
    begin : g_ack
        trb_ack_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (a_ctl[j]),
            .seq_in     (seq_reg),
            .free_in    (a_chain[j]),
            .free_out   (a_chain[j+1]),
            .first_free (a_first[j]),
            .valid      (a_valid[j]),
            .match      (a_match[j]),
            .seq        (a_seq[j])
        );
    end

    always_comb
    begin
        hit_len = '0;
        hit_hd  = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            hit_len = hit_len | (e_match[i] ? e_len[i] : 16'd0);
            hit_hd  = hit_hd  | (e_match[i] ? e_hd[i]  : 16'd0);
        end
        a_count = '0;
        for (int j = 0; j < ACK_ENTRIES; j++)
        begin
            a_count = a_count + ACNT_W'(a_valid[j]);
        end
    end

    assign sum_bytes = {1'b0, held_reg} + {17'd0, len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_BYTES_RST;
        end
        else if (max_buffer_bytes_we)
        begin
            max_reg <= max_buffer_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            exp_reg      <= '0;
            t_idx_reg    <= '0;
            a_idx_reg    <= '0;
            best_vld_reg <= 1'b0;
            remain_reg   <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            exp_reg      <= exp_next;
            t_idx_reg    <= t_idx_next;
            a_idx_reg    <= a_idx_next;
            best_vld_reg <= best_vld_next;
            remain_reg   <= remain_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd_t'(command);
            seq_reg <= segment_seq;
            len_reg <= segment_length;
            hd_reg  <= packet_handle;
        end
        best_key_reg <= best_key_next;
        best_t_reg   <= best_t_next;
        best_a_reg   <= best_a_next;
        status_reg   <= status_next;
        hout_reg     <= hout_next;
        sout_reg     <= sout_next;
        last_reg     <= last_next;
        ovf_reg      <= ovf_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        exp_next      = exp_reg;
        t_idx_next    = t_idx_reg;
        a_idx_next    = a_idx_reg;
        best_vld_next = best_vld_reg;
        best_key_next = best_key_reg;
        best_t_next   = best_t_reg;
        best_a_next   = best_a_reg;
        remain_next   = remain_reg;
        strobe_next   = 1'b0;
        status_next   = status_reg;
        hout_next     = 16'd0;
        sout_next     = sout_reg;
        last_next     = 1'b1;
        ovf_next      = 1'b0;
        cur_take      = 1'b0;
        cur_key       = '0;
        f_key         = best_key_reg;
        f_t           = best_t_reg;
        f_a           = best_a_reg;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            e_ctl[i] = '0;
        end
        for (int j = 0; j < ACK_ENTRIES; j++)
        begin
            a_ctl[j] = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        strobe_next = 1'b1;
                        sout_next   = seq_reg;
                        if (sum_bytes > {1'b0, max_reg})
                        begin
                            status_next = ST_OVER;
                        end
                        else
                        begin
                            if (|e_match)
                            begin
                                status_next = ST_DUP;
                            end
                            else if (e_chain[TABLE_ENTRIES])
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_STORED;
                                held_next   = sum_bytes[31:0];
                                for (int i = 0; i < TABLE_ENTRIES; i++)
                                begin
                                    e_ctl[i].write = e_first[i];
                                end
                            end
                            if (!(|e_match) && e_chain[TABLE_ENTRIES])
                            begin
                                ovf_next = 1'b0;
                            end
                            else if (!(|a_match))
                            begin
                                if (a_chain[ACK_ENTRIES])
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    for (int j = 0; j < ACK_ENTRIES; j++)
                                    begin
                                        a_ctl[j].write = a_first[j];
                                    end
                                end
                            end
                        end
                    end
                    CMD_NEXT:
                    begin
                        if (|e_match)
                        begin
                            strobe_next = 1'b1;
                            status_next = ST_POPPED;
                            hout_next   = hit_hd;
                            sout_next   = exp_reg;
                            exp_next    = exp_reg + {16'd0, hit_len};
                            held_next   = held_reg - {16'd0, hit_len};
                            for (int i = 0; i < TABLE_ENTRIES; i++)
                            begin
                                e_ctl[i].drop = e_match[i];
                            end
                        end
                        else if (!(|e_valid))
                        begin
                            strobe_next = 1'b1;
                            status_next = ST_EMPTY;
                            sout_next   = '0;
                        end
                        else
                        begin
                            state_next    = S_PEEK;
                            t_idx_next    = '0;
                            best_vld_next = 1'b0;
                        end
                    end
                    CMD_ACKS:
                    begin
                        if (a_count == '0)
                        begin
                            strobe_next = 1'b1;
                            status_next = ST_NOACK;
                            sout_next   = '0;
                        end
                        else
                        begin
                            state_next    = S_DRAIN;
                            a_idx_next    = '0;
                            best_vld_next = 1'b0;
                            remain_next   = (int'(a_count) > RESULT_CAP)
                                          ? ACNT_W'(RESULT_CAP) : a_count;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PEEK:
            begin
                cur_key  = e_seq[t_idx_reg] - exp_reg;
                cur_take = e_valid[t_idx_reg] && (!best_vld_reg || cur_key < best_key_reg);
                if (cur_take)
                begin
                    f_key = cur_key;
                    f_t   = t_idx_reg;
                end
                best_vld_next = best_vld_reg | cur_take;
                best_key_next = f_key;
                best_t_next   = f_t;
                if (t_idx_reg == TIDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next  = S_IDLE;
                    strobe_next = 1'b1;
                    status_next = ST_PEEKED;
                    hout_next   = e_hd[f_t];
                    sout_next   = e_seq[f_t];
                end
                else
                begin
                    t_idx_next = t_idx_reg + TIDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                cur_key  = a_seq[a_idx_reg];
                cur_take = a_valid[a_idx_reg] && (!best_vld_reg || cur_key < best_key_reg);
                if (cur_take)
                begin
                    f_key = cur_key;
                    f_a   = a_idx_reg;
                end
                best_vld_next = best_vld_reg | cur_take;
                best_key_next = f_key;
                best_a_next   = f_a;
                if (a_idx_reg == AIDX_W'(ACK_ENTRIES - 1))
                begin
                    strobe_next     = 1'b1;
                    status_next     = ST_ACK;
                    sout_next       = f_key;
                    last_next       = (remain_reg == ACNT_W'(1));
                    a_ctl[f_a].drop = 1'b1;
                    remain_next     = remain_reg - ACNT_W'(1);
                    a_idx_next      = '0;
                    best_vld_next   = 1'b0;
                    if (remain_reg == ACNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    a_idx_next = a_idx_reg + AIDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy              = (state_reg != S_IDLE);
    assign result_valid      = strobe_reg;
    assign status            = status_reg;
    assign handle_out        = hout_reg;
    assign seq_out           = sout_reg;
    assign last_result       = last_reg;
    assign bytes_in_buffer   = held_reg;
    assign next_expected_seq = exp_reg;
    assign ack_overflow      = ovf_reg;

    `TRB_ASSERT(a_entry_match_unique, clk, rst_n, $onehot0(e_match))
    `TRB_ASSERT(a_ack_match_unique, clk, rst_n, $onehot0(a_match))
    `TRB_ASSERT(a_single_result_last, clk, rst_n, (strobe_reg && status_reg != ST_ACK) |-> last_reg)
    `TRB_NEVER(a_drain_empty_slot, clk, rst_n, state_reg == S_DRAIN && a_count == '0)
endmodule
